>>> design/ppb_pkg.sv
// Shared package for the peak programme meter ballistics block.
// Holds field widths, mode and register codes, coefficient constants and
// the configuration struct. Depends on nothing.
package ppb_pkg;

   localparam int CHANNELS   = 2;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int SAMPLE_W   = 24;
   localparam int LEVEL_W    = 24;
   localparam int COEFF_W    = 25;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_BITS  = 24;

   localparam logic [COEFF_W-1:0] Q24_ONE  = 25'd16777216;
   localparam logic [COEFF_W-1:0] Q24_HALF = 25'd8388608;
   localparam logic [COEFF_W-1:0] M3_GAIN  = 25'd11863169;

   localparam logic [MODE_W-1:0] MODE_AB = 2'd0;
   localparam logic [MODE_W-1:0] MODE_M3 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_M6 = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY       = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  matrix_mode;
      logic [COEFF_W-1:0] attack;
      logic [COEFF_W-1:0] decay;
   } cfg_type;

endpackage

>>> design/ppb_mul.sv
// Shared Q1.24 multiplier of the meter ballistics block, registered output.
// Depends on ppb_pkg for widths.
module ppb_mul (
   input  logic                          clock,
   input  logic [ppb_pkg::COEFF_W-1:0]   op_a,
   input  logic [ppb_pkg::COEFF_W-1:0]   op_b,
   output logic [ppb_pkg::COEFF_W-1:0]   prod
);

   logic [2*ppb_pkg::COEFF_W-1:0] full;
   logic [ppb_pkg::COEFF_W-1:0]   prod_ff;
   logic [ppb_pkg::COEFF_W-1:0]   prod_in;

   always_comb begin
      full    = op_a * op_b;
      prod_in = full[ppb_pkg::FRAC_BITS +: ppb_pkg::COEFF_W];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> design/ppb_csr.sv
// Configuration registers of the meter ballistics block.
// Coefficients above one are saturated when written. Depends on ppb_pkg.
module ppb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ppb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppb_pkg::COEFF_W-1:0]     csr_wdata,
   output ppb_pkg::cfg_type                cfg
);

   ppb_pkg::cfg_type             cfg_ff;
   ppb_pkg::cfg_type             cfg_in;
   logic [ppb_pkg::COEFF_W-1:0]  sat_data;

   always_comb begin
      sat_data = (csr_wdata > ppb_pkg::Q24_ONE) ? ppb_pkg::Q24_ONE : csr_wdata;
      cfg_in   = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ppb_pkg::CSR_MATRIX_MODE: cfg_in.matrix_mode = csr_wdata[ppb_pkg::MODE_W-1:0];
            ppb_pkg::CSR_ATTACK:      cfg_in.attack      = sat_data;
            ppb_pkg::CSR_DECAY:       cfg_in.decay       = sat_data;
            default:                  cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_mode <= ppb_pkg::MODE_AB;
         cfg_ff.attack      <= ppb_pkg::Q24_ONE;
         cfg_ff.decay       <= ppb_pkg::Q24_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/ppm_peak_ballistics_top.sv
// Top level of the two-channel peak programme meter ballistics block.
// Holds the sequencer, meter state and result register; uses ppb_pkg,
// ppb_csr and ppb_mul.

// Each of the two channels of a sample frame item runs three dependent
// multiplies (magnitude scaling, attack, decay) through the single shared
// multiplier, plus an add and an update step (states MAG, ATK, ADD, DCY,
// UPD); DONE then hands the item to the result register, waiting while it
// holds an untaken result. A restart item, or a frame in the unused matrix
// mode, goes straight to DONE. A finished item waits in the result
// register, so the next item may start before the previous one is taken.
module ppm_peak_ballistics_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ppb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ppb_pkg::COEFF_W-1:0]           csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [ppb_pkg::SAMPLE_W-1:0]   req_sample_left,
   input  logic signed [ppb_pkg::SAMPLE_W-1:0]   req_sample_right,
   input  logic [ppb_pkg::CH_W-1:0]              req_channel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_level_zero,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_level_one,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_max_zero,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_max_one,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_min_zero,
   output logic [ppb_pkg::LEVEL_W-1:0]           rsp_min_one
);

   localparam int LW = ppb_pkg::LEVEL_W;
   localparam int CW = ppb_pkg::COEFF_W;
   localparam int SW = ppb_pkg::SAMPLE_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MAG  = 7'b0000010,
      S_ATK  = 7'b0000100,
      S_ADD  = 7'b0001000,
      S_DCY  = 7'b0010000,
      S_UPD  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   function automatic logic [CW-1:0] abs_wide(input logic signed [CW-1:0] v);
      abs_wide = v[CW-1] ? CW'(-v) : CW'(v);
   endfunction

   ppb_pkg::cfg_type cfg;

   state_type state_ff, state_in;
   logic [ppb_pkg::CH_W-1:0] ch_ff, ch_in;
   logic signed [SW-1:0] left_ff, left_in, right_ff, right_in;
   logic rise_ff, rise_in;
   logic [LW-1:0] work_ff, work_in;
   logic [LW-1:0] level_ff [ppb_pkg::CHANNELS];
   logic [LW-1:0] level_in [ppb_pkg::CHANNELS];
   logic [LW-1:0] high_ff  [ppb_pkg::CHANNELS];
   logic [LW-1:0] high_in  [ppb_pkg::CHANNELS];
   logic [LW-1:0] low_ff   [ppb_pkg::CHANNELS];
   logic [LW-1:0] low_in   [ppb_pkg::CHANNELS];
   logic rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] out_level0_ff, out_level0_in, out_level1_ff, out_level1_in;
   logic [LW-1:0] out_max0_ff, out_max0_in, out_max1_ff, out_max1_in;
   logic [LW-1:0] out_min0_ff, out_min0_in, out_min1_ff, out_min1_in;

   logic signed [CW-1:0] sum_w, dif_w;
   logic [CW-1:0] mag_src, gain, op_a, op_b, prod;
   logic [LW-1:0] mag, diff, new_level, cur_level;
   logic accept, load_out;

   ppb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppb_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sum_w     = CW'(left_ff) + CW'(right_ff);
      dif_w     = CW'(left_ff) - CW'(right_ff);
      cur_level = level_ff[ch_ff];
      mag       = prod[LW-1:0];
      diff      = mag - cur_level;
      new_level = prod[LW-1:0];
      if (cfg.matrix_mode == ppb_pkg::MODE_AB) begin
         mag_src = (ch_ff == '0) ? abs_wide(CW'(left_ff)) : abs_wide(CW'(right_ff));
      end else begin
         mag_src = (ch_ff == '0) ? abs_wide(sum_w) : abs_wide(dif_w);
      end
      unique case (cfg.matrix_mode)
         ppb_pkg::MODE_AB:   gain = ppb_pkg::Q24_ONE;
         ppb_pkg::MODE_M3:   gain = ppb_pkg::M3_GAIN;
         ppb_pkg::MODE_M6:   gain = ppb_pkg::Q24_HALF;
         ppb_pkg::MODE_NONE: gain = '0;
      endcase
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_MAG: begin
            op_a = mag_src;
            op_b = gain;
         end
         S_ATK: begin
            op_a = cfg.attack;
            op_b = {1'b0, diff};
         end
         S_DCY: begin
            op_a = {1'b0, work_ff};
            op_b = cfg.decay;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rise_in      = rise_ff;
      work_in      = work_ff;
      level_in     = level_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      rsp_valid_in = rsp_valid_ff;
      out_level0_in = out_level0_ff;
      out_level1_in = out_level1_ff;
      out_max0_in   = out_max0_ff;
      out_max1_in   = out_max1_ff;
      out_min0_in   = out_min0_ff;
      out_min1_in   = out_min1_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               left_in  = req_sample_left;
               right_in = req_sample_right;
               ch_in    = '0;
               if (req_kind) begin
                  high_in[req_channel] = level_ff[req_channel];
                  low_in[req_channel]  = level_ff[req_channel];
                  state_in = S_DONE;
               end else if (cfg.matrix_mode == ppb_pkg::MODE_NONE) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MAG;
               end
            end
         end
         S_MAG: state_in = S_ATK;
         S_ATK: begin
            rise_in  = (mag > cur_level);
            state_in = S_ADD;
         end
         S_ADD: begin
            work_in  = cur_level + (rise_ff ? prod[LW-1:0] : '0);
            state_in = S_DCY;
         end
         S_DCY: state_in = S_UPD;
         S_UPD: begin
            level_in[ch_ff] = new_level;
            if (new_level > high_ff[ch_ff]) begin
               high_in[ch_ff] = new_level;
            end
            if (new_level < low_ff[ch_ff]) begin
               low_in[ch_ff] = new_level;
            end
            if (ch_ff == ppb_pkg::CH_W'(ppb_pkg::CHANNELS - 1)) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_MAG;
            end
         end
         S_DONE: begin
            if (load_out) begin
               rsp_valid_in  = 1'b1;
               out_level0_in = level_ff[0];
               out_level1_in = level_ff[1];
               out_max0_in   = high_ff[0];
               out_max1_in   = high_ff[1];
               out_min0_in   = low_ff[0];
               out_min1_in   = low_ff[1];
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ppb_pkg::CHANNELS; i++) begin
            level_ff[i] <= '0;
            high_ff[i]  <= '0;
            low_ff[i]   <= '1;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      right_ff      <= right_in;
      rise_ff       <= rise_in;
      work_ff       <= work_in;
      out_level0_ff <= out_level0_in;
      out_level1_ff <= out_level1_in;
      out_max0_ff   <= out_max0_in;
      out_max1_ff   <= out_max1_in;
      out_min0_ff   <= out_min0_in;
      out_min1_ff   <= out_min1_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level_zero = out_level0_ff;
   assign rsp_level_one  = out_level1_ff;
   assign rsp_max_zero   = out_max0_ff;
   assign rsp_max_one    = out_max1_ff;
   assign rsp_min_zero   = out_min0_ff;
   assign rsp_min_one    = out_min1_ff;

   a_restart_keeps_levels: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind) |=> ($stable(level_ff[0]) && $stable(level_ff[1])))
      else $error("A restart item changed a meter level.");

   a_level_below_high: assert property (@(posedge clock) disable iff (reset)
      (level_ff[0] <= high_ff[0]) && (level_ff[1] <= high_ff[1]))
      else $error("A meter level exceeds its maximum hold.");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("A result appeared without a finished item.");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAG) |=> !accept ##1 !accept)
      else $error("An item was accepted while a frame was in progress.");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the peak programme meter ballistics block.
// Holds a cycle-free predictor of levels and holds, a driver and a checker;
// depends on ppb_pkg and ppm_peak_ballistics_top.
`timescale 1ns / 1ps

module tb;

   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_RESTART = 1'b1;
   localparam logic [ppb_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [ppb_pkg::COEFF_W-1:0] COEFF_ALL_ONES = '1;
   localparam logic signed [ppb_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [ppb_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic [ppb_pkg::LEVEL_W-1:0] level_zero;
      logic [ppb_pkg::LEVEL_W-1:0] level_one;
      logic [ppb_pkg::LEVEL_W-1:0] max_zero;
      logic [ppb_pkg::LEVEL_W-1:0] max_one;
      logic [ppb_pkg::LEVEL_W-1:0] min_zero;
      logic [ppb_pkg::LEVEL_W-1:0] min_one;
   } meter_report_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [ppb_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [ppb_pkg::COEFF_W-1:0]         csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_kind = 1'b0;
   logic signed [ppb_pkg::SAMPLE_W-1:0] req_sample_left = '0;
   logic signed [ppb_pkg::SAMPLE_W-1:0] req_sample_right = '0;
   logic [ppb_pkg::CH_W-1:0]            req_channel = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_level_zero;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_level_one;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_max_zero;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_max_one;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_min_zero;
   logic [ppb_pkg::LEVEL_W-1:0]         rsp_min_one;

   ppm_peak_ballistics_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level_zero   (rsp_level_zero),
      .rsp_level_one    (rsp_level_one),
      .rsp_max_zero     (rsp_max_zero),
      .rsp_max_one      (rsp_max_one),
      .rsp_min_zero     (rsp_min_zero),
      .rsp_min_one      (rsp_min_one)
   );

   logic [ppb_pkg::MODE_W-1:0]  cfg_mode;
   logic [ppb_pkg::COEFF_W-1:0] cfg_attack;
   logic [ppb_pkg::COEFF_W-1:0] cfg_decay;
   logic [ppb_pkg::LEVEL_W-1:0] level_now [ppb_pkg::CHANNELS];
   logic [ppb_pkg::LEVEL_W-1:0] peak_hold [ppb_pkg::CHANNELS];
   logic [ppb_pkg::LEVEL_W-1:0] trough_hold [ppb_pkg::CHANNELS];

   meter_report_type expected_levels [$];
   int  error_count = 0;
   int  rsp_hold = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;
   bit  req_live = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb NOT OK");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic reset_model();
      cfg_mode = ppb_pkg::MODE_AB;
      cfg_attack = ppb_pkg::Q24_ONE;
      cfg_decay = ppb_pkg::Q24_ONE;
      for (int i = 0; i < ppb_pkg::CHANNELS; i++) begin
         level_now[i] = '0;
         peak_hold[i] = '0;
         trough_hold[i] = '1;
      end
   endtask

   task automatic update_channel(input int ch, input longint unsigned mag);
      longint unsigned lvl;
      longint unsigned att;
      longint unsigned dec;
      att = 64'((cfg_attack > ppb_pkg::Q24_ONE) ? ppb_pkg::Q24_ONE : cfg_attack);
      dec = 64'((cfg_decay > ppb_pkg::Q24_ONE) ? ppb_pkg::Q24_ONE : cfg_decay);
      lvl = 64'(level_now[ch]);
      if (mag > lvl) lvl = lvl + ((att * (mag - lvl)) >> ppb_pkg::FRAC_BITS);
      lvl = (lvl * dec) >> ppb_pkg::FRAC_BITS;
      level_now[ch] = lvl[ppb_pkg::LEVEL_W-1:0];
      if (level_now[ch] > peak_hold[ch]) peak_hold[ch] = level_now[ch];
      if (level_now[ch] < trough_hold[ch]) trough_hold[ch] = level_now[ch];
   endtask

   task automatic predict_item(input logic kind,
                               input logic signed [ppb_pkg::SAMPLE_W-1:0] left,
                               input logic signed [ppb_pkg::SAMPLE_W-1:0] right,
                               input logic ch);
      longint sl;
      longint sr;
      meter_report_type rep;
      sl = 64'(left);
      sr = 64'(right);
      if (kind == KIND_FRAME) begin
         case (cfg_mode)
            ppb_pkg::MODE_AB: begin
               update_channel(0, magnitude(sl));
               update_channel(1, magnitude(sr));
            end
            ppb_pkg::MODE_M3: begin
               update_channel(0, (magnitude(sl + sr) * ppb_pkg::M3_GAIN) >> ppb_pkg::FRAC_BITS);
               update_channel(1, (magnitude(sl - sr) * ppb_pkg::M3_GAIN) >> ppb_pkg::FRAC_BITS);
            end
            ppb_pkg::MODE_M6: begin
               update_channel(0, magnitude(sl + sr) >> 1);
               update_channel(1, magnitude(sl - sr) >> 1);
            end
            default: ;
         endcase
      end else begin
         peak_hold[ch] = level_now[ch];
         trough_hold[ch] = level_now[ch];
      end
      rep.level_zero = level_now[0];
      rep.level_one  = level_now[1];
      rep.max_zero   = peak_hold[0];
      rep.max_one    = peak_hold[1];
      rep.min_zero   = trough_hold[0];
      rep.min_one    = trough_hold[1];
      expected_levels.push_back(rep);
   endtask

   task automatic write_csr(input logic [ppb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ppb_pkg::COEFF_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         ppb_pkg::CSR_MATRIX_MODE: cfg_mode = data[ppb_pkg::MODE_W-1:0];
         ppb_pkg::CSR_ATTACK:      cfg_attack = data;
         ppb_pkg::CSR_DECAY:       cfg_decay = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // The unused upper bits of the mode write carry random data.
   task automatic set_mode(input logic [ppb_pkg::MODE_W-1:0] mode);
      write_csr(ppb_pkg::CSR_MATRIX_MODE,
                {(ppb_pkg::COEFF_W-ppb_pkg::MODE_W)'($urandom), mode});
   endtask

   task automatic wait_idle();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live = 1'b0;
      end
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic offer_item(input logic kind,
                             input logic signed [ppb_pkg::SAMPLE_W-1:0] left,
                             input logic signed [ppb_pkg::SAMPLE_W-1:0] right,
                             input logic ch);
      int gap;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         if (req_live) req_valid <= 1'b0;
         req_live = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_live = 1'b1;
      req_kind <= kind;
      req_sample_left <= left;
      req_sample_right <= right;
      req_channel <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(kind, left, right, ch);
   endtask

   task automatic offer_frame(input logic signed [ppb_pkg::SAMPLE_W-1:0] left,
                              input logic signed [ppb_pkg::SAMPLE_W-1:0] right);
      offer_item(KIND_FRAME, left, right, 1'($urandom));
   endtask

   task automatic offer_restart(input logic ch);
      offer_item(KIND_RESTART, ppb_pkg::SAMPLE_W'($urandom), ppb_pkg::SAMPLE_W'($urandom), ch);
   endtask

   task automatic compare_field(input string name, input logic [ppb_pkg::LEVEL_W-1:0] got,
                                input logic [ppb_pkg::LEVEL_W-1:0] want);
      if (got !== want) report_error($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_result();
      meter_report_type want;
      if (expected_levels.size() == 0) begin
         report_error("result with no item outstanding");
      end else begin
         want = expected_levels.pop_front();
         compare_field("level_zero", rsp_level_zero, want.level_zero);
         compare_field("level_one",  rsp_level_one,  want.level_one);
         compare_field("max_zero",   rsp_max_zero,   want.max_zero);
         compare_field("max_one",    rsp_max_one,    want.max_one);
         compare_field("min_zero",   rsp_min_zero,   want.min_zero);
         compare_field("min_one",    rsp_min_one,    want.min_one);
      end
   endtask

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            check_result();
            stall = recv_idle ? $urandom_range(0, 15) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [ppb_pkg::SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return ppb_pkg::SAMPLE_W'($urandom_range(0, 511) - 256);
         default: return ppb_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [ppb_pkg::COEFF_W-1:0] rand_attack();
      case ($urandom_range(0, 3))
         0:       return ppb_pkg::Q24_ONE;
         1:       return ppb_pkg::COEFF_W'($urandom_range(1, ppb_pkg::Q24_ONE));
         2:       return ppb_pkg::COEFF_W'($urandom_range(ppb_pkg::Q24_ONE + 1, COEFF_ALL_ONES));
         default: return ppb_pkg::COEFF_W'($urandom_range(1, 1 << 20));
      endcase
   endfunction

   function automatic logic [ppb_pkg::COEFF_W-1:0] rand_decay();
      case ($urandom_range(0, 3))
         0:       return ppb_pkg::Q24_ONE;
         1:       return ppb_pkg::Q24_ONE - ppb_pkg::COEFF_W'($urandom_range(1, 50000));
         2:       return ppb_pkg::COEFF_W'($urandom_range(ppb_pkg::Q24_ONE + 1, COEFF_ALL_ONES));
         default: return ppb_pkg::COEFF_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_state_ab();
      offer_restart(1'b1);
      offer_frame(SAMPLE_MAX, SAMPLE_MIN);
      offer_frame('0, '0);
      offer_restart(1'b0);
      offer_frame(-24'sd1, 24'sd1);
      wait_idle();
   endtask

   task automatic test_stereo_modes();
      set_mode(ppb_pkg::MODE_M3);
      offer_frame(SAMPLE_MAX, SAMPLE_MAX);
      offer_frame(SAMPLE_MIN, SAMPLE_MIN);
      offer_frame(SAMPLE_MAX, SAMPLE_MIN);
      wait_idle();
      write_csr(ppb_pkg::CSR_DECAY, ppb_pkg::Q24_HALF);
      offer_frame(SAMPLE_MIN, SAMPLE_MAX);
      offer_frame(24'sd1000, -24'sd1000);
      wait_idle();
      set_mode(ppb_pkg::MODE_M6);
      offer_frame(SAMPLE_MIN, SAMPLE_MIN);
      offer_frame(SAMPLE_MAX, SAMPLE_MIN);
      offer_frame(SAMPLE_MIN, SAMPLE_MAX);
      wait_idle();
      set_mode(ppb_pkg::MODE_NONE);
      offer_frame(SAMPLE_MAX, SAMPLE_MIN);
      offer_restart(1'b0);
      offer_frame(SAMPLE_MIN, SAMPLE_MAX);
      wait_idle();
   endtask

   task automatic test_coeff_extremes();
      set_mode(ppb_pkg::MODE_AB);
      write_csr(ppb_pkg::CSR_ATTACK, '0);
      write_csr(ppb_pkg::CSR_DECAY, ppb_pkg::Q24_ONE);
      offer_frame(SAMPLE_MAX, SAMPLE_MIN);
      wait_idle();
      write_csr(ppb_pkg::CSR_ATTACK, 25'd1);
      write_csr(ppb_pkg::CSR_DECAY, '0);
      offer_frame(SAMPLE_MAX, SAMPLE_MAX);
      offer_restart(1'b1);
      wait_idle();
      write_csr(ppb_pkg::CSR_ATTACK, COEFF_ALL_ONES);
      write_csr(ppb_pkg::CSR_DECAY, COEFF_ALL_ONES);
      offer_frame(SAMPLE_MIN, 24'sd12345);
      wait_idle();
      write_csr(CSR_UNUSED, COEFF_ALL_ONES);
      offer_frame(24'sd77, SAMPLE_MAX);
      offer_restart(1'b0);
      offer_restart(1'b1);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic signed [ppb_pkg::SAMPLE_W-1:0] left;
      logic signed [ppb_pkg::SAMPLE_W-1:0] right;
      int count;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 5) set_mode(ppb_pkg::MODE_NONE);
         else set_mode(ppb_pkg::MODE_W'(phase % 3));
         write_csr(ppb_pkg::CSR_ATTACK, rand_attack());
         write_csr(ppb_pkg::CSR_DECAY, rand_decay());
         if ($urandom_range(0, 1) == 0) write_csr(CSR_UNUSED, ppb_pkg::COEFF_W'($urandom));
         send_idle = (phase != 3);
         recv_idle = (phase != 3);
         count = (phase == 5) ? 30 : 140;
         for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               offer_restart(1'($urandom));
            end else begin
               left = rand_sample();
               case ($urandom_range(0, 5))
                  0:       right = left;
                  1:       right = -left;
                  default: right = rand_sample();
               endcase
               offer_frame(left, right);
            end
            if ($urandom_range(0, 49) == 0) wait_idle();
         end
         wait_idle();
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      set_mode(ppb_pkg::MODE_M6);
      write_csr(ppb_pkg::CSR_ATTACK, ppb_pkg::Q24_HALF);
      write_csr(ppb_pkg::CSR_DECAY, ppb_pkg::Q24_ONE - 25'd4096);
      send_idle = 1'b0;
      rsp_hold = 300;
      for (int n = 0; n < 24; n++) begin
         if (n % 6 == 5) offer_restart(1'($urandom));
         else offer_frame(rand_sample(), rand_sample());
      end
      wait_idle();
      send_idle = 1'b1;
   endtask

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state_ab();
      test_stereo_modes();
      test_coeff_extremes();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
